// ===== rtl/inverse_adjacency_list_builder_assert.svh =====
// Assertion macros for the inverse adjacency list builder.
`ifndef INVERSE_ADJACENCY_LIST_BUILDER_ASSERT_SVH
`define INVERSE_ADJACENCY_LIST_BUILDER_ASSERT_SVH

// Checked only while out of reset.
`define IAB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IAB_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/iab_pkg.sv =====
// Shared types and constants of the inverse adjacency list builder.
package iab_pkg;

    localparam int NODES          = 4096;
    localparam int SLOTS_PER_NODE = 16;
    localparam int POINT_BITS     = 16;

    localparam int NODE_ID_W   = 12;
    localparam int CFG_W       = 13;
    localparam int COUNT_W     = 5;
    localparam int NODE_AW     = $clog2(NODES);
    localparam int LEN_W       = $clog2(SLOTS_PER_NODE + 1);
    localparam int NODE_DW     = LEN_W + 1;
    localparam int SLOT_AW     = $clog2(NODES * SLOTS_PER_NODE);
    localparam int NODE_COUNT_RESET = NODES;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [NODE_ID_W-1:0]  node_id;
        logic [POINT_BITS-1:0] point_id;
    } t_item;

    typedef struct packed {
        logic [NODE_ID_W-1:0]  node_id_out;
        logic [COUNT_W-1:0]    point_count;
        logic [POINT_BITS-1:0] point_out;
        logic                  has_point;
        logic                  overflowed;
        logic                  out_of_range;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        logic [NODE_DW-1:0] wdata;
        logic               re;
        logic [NODE_AW-1:0] raddr;
    } t_node_req;

    typedef struct packed {
        logic                  we;
        logic [SLOT_AW-1:0]    waddr;
        logic [POINT_BITS-1:0] wdata;
        logic                  re;
        logic [SLOT_AW-1:0]    raddr;
    } t_slot_req;

endpackage

// ===== rtl/iab_ram.sv =====
// Generic simple dual-port RAM with registered read.
module iab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/iab_ctrl.sv =====
// Sequencer: table clear, node lookup/update, slot append and query streaming.
module iab_ctrl
    import iab_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_item                 i_item,
    input  logic                  i_cfg_valid,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output t_node_req             o_node_req,
    input  logic [NODE_DW-1:0]    i_node_rdata,
    output t_slot_req             o_slot_req,
    input  logic [POINT_BITS-1:0] i_slot_rdata,
    output logic                  o_strobe,
    output t_result               o_result
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_STREAM
    } t_state;

    t_state             r_state, n_state;
    logic [NODE_AW-1:0] r_clr, n_clr;
    logic [CFG_W-1:0]   r_node_count;
    t_item              r_item, n_item;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    logic               r_use_slot, n_use_slot;
    t_result            r_out, n_out;

    logic               accept;
    logic               node_ok;
    logic [LEN_W-1:0]   len;
    logic               ovf;
    logic               full;
    logic [SLOT_AW-1:0] base;

    assign accept  = i_start && (r_state == S_IDLE);
    assign node_ok = ({1'b0, r_item.node_id} < r_node_count)
                  && ({1'b0, r_item.node_id} < CFG_W'(NODES));
    assign len     = i_node_rdata[LEN_W-1:0];
    assign ovf     = i_node_rdata[LEN_W];
    assign full    = (len >= LEN_W'(SLOTS_PER_NODE));
    assign base    = SLOT_AW'(r_item.node_id) * SLOT_AW'(SLOTS_PER_NODE);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_item      = r_item;
        n_len       = r_len;
        n_idx       = r_idx;
        n_out_valid = 1'b0;
        n_use_slot  = 1'b0;
        n_out       = r_out;
        o_node_req  = '0;
        o_slot_req  = '0;

        case (r_state)
            S_CLEAR: begin
                o_node_req.we    = 1'b1;
                o_node_req.waddr = r_clr;
                o_node_req.wdata = '0;
                n_clr            = r_clr + 1'b1;
                if (r_clr == NODE_AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_item           = i_item;
                    o_node_req.re    = 1'b1;
                    o_node_req.raddr = i_item.node_id[NODE_AW-1:0];
                    n_state          = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_IDLE;
                if (r_item.action == ACT_ADD) begin
                    if (node_ok) begin
                        o_node_req.we    = 1'b1;
                        o_node_req.waddr = r_item.node_id[NODE_AW-1:0];
                        if (full) begin
                            o_node_req.wdata = {1'b1, len};
                        end else begin
                            o_node_req.wdata = {ovf, len + 1'b1};
                            o_slot_req.we    = 1'b1;
                            o_slot_req.waddr = base + SLOT_AW'(len);
                            o_slot_req.wdata = r_item.point_id;
                        end
                    end
                end else begin
                    n_out_valid       = 1'b1;
                    n_out.node_id_out = r_item.node_id;
                    n_out.point_count = node_ok ? COUNT_W'(len) : '0;
                    n_out.point_out   = '0;
                    n_out.has_point   = node_ok && (len != '0);
                    n_out.overflowed  = node_ok && ovf;
                    n_out.out_of_range = !node_ok;
                    n_out.last        = !node_ok || (len <= LEN_W'(1));
                    if (node_ok && (len != '0)) begin
                        n_use_slot       = 1'b1;
                        o_slot_req.re    = 1'b1;
                        o_slot_req.raddr = base;
                        n_len            = len;
                        n_idx            = LEN_W'(1);
                        if (len > LEN_W'(1)) begin
                            n_state = S_STREAM;
                        end
                    end
                end
            end
            S_STREAM: begin
                n_out_valid      = 1'b1;
                n_use_slot       = 1'b1;
                n_out.last       = (r_idx == r_len - 1'b1);
                o_slot_req.re    = 1'b1;
                o_slot_req.raddr = base + SLOT_AW'(r_idx);
                n_idx            = r_idx + 1'b1;
                if (r_idx == r_len - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_node_count <= CFG_W'(NODE_COUNT_RESET);
            r_out_valid  <= 1'b0;
            r_use_slot   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_use_slot  <= n_use_slot;
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
        end
        r_item <= n_item;
        r_len  <= n_len;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_out_valid;

    always_comb begin
        o_result           = r_out;
        o_result.point_out = r_use_slot ? i_slot_rdata : '0;
    end

endmodule

// ===== rtl/inverse_adjacency_list_builder.sv =====
// Top level of the inverse adjacency list builder.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------
//  input    | start & !busy             | i_item   (t_item)
//  result   | o_strobe, one cycle each  | o_result (t_result)
//  config   | i_cfg_valid & o_cfg_ready | i_cfg_data (node_count)
//
// An add item: accept, then one node-table read-modify-write plus slot write.
// A query item gives one result per stored point, or one when empty or out of range;
// the slot memory read port delivers one point per cycle.
// After reset the node table is cleared, one entry per cycle, while busy stays high.
// Results cannot be stalled; config writes are taken in any cycle.
module inverse_adjacency_list_builder
    import iab_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_strobe,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_node_req             node_req;
    t_slot_req             slot_req;
    logic [NODE_DW-1:0]    node_rdata;
    logic [POINT_BITS-1:0] slot_rdata;

    assign o_cfg_ready = 1'b1;

    iab_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_item       (i_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_node_req   (node_req),
        .i_node_rdata (node_rdata),
        .o_slot_req   (slot_req),
        .i_slot_rdata (slot_rdata),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

    iab_ram #(
        .WIDTH (NODE_DW),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_req.we),
        .i_waddr (node_req.waddr),
        .i_wdata (node_req.wdata),
        .i_re    (node_req.re),
        .i_raddr (node_req.raddr),
        .o_rdata (node_rdata)
    );

    iab_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (NODES * SLOTS_PER_NODE)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_req.we),
        .i_waddr (slot_req.waddr),
        .i_wdata (slot_req.wdata),
        .i_re    (slot_req.re),
        .i_raddr (slot_req.raddr),
        .o_rdata (slot_rdata)
    );

endmodule

// ===== rtl/iab_checker.sv =====
// Port-level checker for the inverse adjacency list builder, with its bind.
`include "inverse_adjacency_list_builder_assert.svh"

module iab_checker
    import iab_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    `IAB_ASSERT_ANY(a_busy_after_reset, i_clk, !i_rst_n |=> busy, "not busy after reset")
    `IAB_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, (start && !busy) |=> busy, "accept without busy")
    `IAB_ASSERT_RST(a_stream_gapless, i_clk, i_rst_n, (o_strobe && !o_result.last) |=> o_strobe, "gap in query stream")
    `IAB_ASSERT_RST(a_empty_is_last, i_clk, i_rst_n, (o_strobe && !o_result.has_point) |-> (o_result.last && (o_result.point_count == '0)), "empty result not single")
    `IAB_ASSERT_RST(a_oor_empty, i_clk, i_rst_n, (o_strobe && o_result.out_of_range) |-> (!o_result.has_point && !o_result.overflowed), "out of range result carries data")

endmodule

bind inverse_adjacency_list_builder iab_checker u_iab_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/sv/tb_inverse_adjacency_list_builder.sv =====
// Self-checking testbench for the inverse adjacency list builder: directed and random adds and queries.
module tb_inverse_adjacency_list_builder;
    import iab_pkg::*;

    class node_list_scoreboard;
        bit [CFG_W-1:0]      node_count = CFG_W'(NODE_COUNT_RESET);
        bit [COUNT_W-1:0]    list_len [NODES];
        bit                  ovf_mark [NODES];
        bit [POINT_BITS-1:0] slots [NODES*SLOTS_PER_NODE];
        t_result             expected_results [$];
        int                  mismatches = 0;

        function void push_result(logic [NODE_ID_W-1:0] node, logic [COUNT_W-1:0] cnt,
                                  logic [POINT_BITS-1:0] pt, logic has, logic ovf,
                                  logic oor, logic lst);
            t_result r;
            r.node_id_out  = node;
            r.point_count  = cnt;
            r.point_out    = pt;
            r.has_point    = has;
            r.overflowed   = ovf;
            r.out_of_range = oor;
            r.last         = lst;
            expected_results.push_back(r);
        endfunction

        function void note_item(t_item it);
            int node;
            int len;
            bit in_use;
            node   = it.node_id;
            in_use = node < node_count;
            len    = list_len[node];
            if (it.action == ACT_ADD) begin
                if (in_use) begin
                    if (len < SLOTS_PER_NODE) begin
                        slots[node*SLOTS_PER_NODE + len] = it.point_id;
                        list_len[node] = COUNT_W'(len + 1);
                    end else begin
                        ovf_mark[node] = 1'b1;
                    end
                end
            end else if (!in_use) begin
                push_result(it.node_id, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
            end else if (len == 0) begin
                push_result(it.node_id, '0, '0, 1'b0, ovf_mark[node], 1'b0, 1'b1);
            end else begin
                for (int i = 0; i < len; i++)
                    push_result(it.node_id, COUNT_W'(len), slots[node*SLOTS_PER_NODE + i],
                                1'b1, ovf_mark[node], 1'b0, i == len - 1);
            end
        endfunction

        function void check_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %p", $time, got);
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            check_field("node_id_out", exp.node_id_out, got.node_id_out);
            check_field("point_count", exp.point_count, got.point_count);
            check_field("point_out", exp.point_out, got.point_out);
            check_field("has_point", exp.has_point, got.has_point);
            check_field("overflowed", exp.overflowed, got.overflowed);
            check_field("out_of_range", exp.out_of_range, got.out_of_range);
            check_field("last", exp.last, got.last);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_item            i_item = '0;
    logic             o_strobe;
    t_result          o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    node_list_scoreboard sb = new;

    inverse_adjacency_list_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.node_count = i_cfg_data;
            if (start && !busy)
                sb.note_item(i_item);
            if (o_strobe)
                sb.check_result(o_result);
        end
    end

    task automatic drive_item(logic act, int node, int pt);
        t_item it;
        it.action   = act;
        it.node_id  = NODE_ID_W'(node);
        it.point_id = POINT_BITS'(pt);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_node_count(int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(int n_items, int idle_pct, int nc);
        int  pool [6];
        int  node;
        logic act;
        pool[0] = 0;
        pool[1] = NODES - 1;
        pool[2] = (nc - 1) % NODES;
        pool[3] = nc % NODES;
        pool[4] = $urandom_range(NODES - 1);
        pool[5] = $urandom_range(NODES - 1);
        write_node_count(nc);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 10)
                node = $urandom_range(NODES - 1);
            else
                node = pool[$urandom_range(5)];
            act = ($urandom_range(99) < 30) ? ACT_QUERY : ACT_ADD;
            drive_item(act, node, $urandom_range(65535));
            if (i == n_items / 2) begin
                wait_quiet();
            end else if ($urandom_range(99) < idle_pct) begin
                start  <= 1'b0;
                i_item <= t_item'($urandom);
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
        wait_quiet();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty node, both point extremes
        drive_item(ACT_QUERY, 0, 16'h1234);
        drive_item(ACT_ADD, 0, 0);
        drive_item(ACT_ADD, 0, 16'hFFFF);
        drive_item(ACT_QUERY, 0, 0);
        // fill the top node past its slots
        for (int i = 0; i < SLOTS_PER_NODE + 1; i++)
            drive_item(ACT_ADD, NODES - 1, $urandom_range(65535));
        drive_item(ACT_QUERY, NODES - 1, 0);
        wait_quiet();

        // single node in use
        write_node_count(1);
        drive_item(ACT_ADD, NODES - 1, 16'h5A5A);
        drive_item(ACT_QUERY, NODES - 1, 0);
        drive_item(ACT_QUERY, 0, 16'hFFFF);
        wait_quiet();

        run_random_phase(45, 11, NODES);
        run_random_phase(45, 50, $urandom_range(2, NODES - 1));
        run_random_phase(45, 0, NODES);

        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
